// ===== rtl/mhpq_pkg.sv =====
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

    localparam int FUNC_W   = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int LEVELS_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT     = 2'd0,
        FUNC_REMOVE_MAX = 2'd1,
        FUNC_DELETE     = 2'd2,
        FUNC_SEARCH     = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_SET_FULL,
        DP_SET_EMPTY,
        DP_INS_PLACE,
        DP_UP_READ,
        DP_UP_MOVE,
        DP_WRITE_VAL,
        DP_READ_ROOT,
        DP_LATCH_REMOVED,
        DP_SCAN,
        DP_TAKE,
        DP_TAKE_LOAD,
        DP_DN_READ_L,
        DP_DN_LATCH_L,
        DP_DN_LATCH_R,
        DP_DN_MOVE,
        DP_TOP_LATCH,
        DP_OUT_LOAD
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_UP_RD,
        S_UP_CMP,
        S_RM_LD,
        S_SCAN,
        S_TAKE,
        S_TAKE_LD,
        S_DN_RDL,
        S_DN_LATL,
        S_DN_LATR,
        S_DN_DEC,
        S_TOP_RD,
        S_TOP_LD,
        S_FIN
    } state_t;

    typedef struct packed {
        logic   req_ready;
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic  req_valid;
        func_t func;
        logic  full;
        logic  empty;
        logic  hole_zero;
        logic  up_greater;
        logic  left_exists;
        logic  right_exists;
        logic  child_big;
        logic  moved;
        logic  scan_found;
        logic  scan_miss;
        logic  take_fill;
        logic  out_free;
    } stat_t;

endpackage

// ===== rtl/mhpq_req_if.sv =====
// Request channel interface: operation code and operand value.
interface mhpq_req_if;
    import mhpq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

// ===== rtl/mhpq_rsp_if.sv =====
// Result channel interface: status, removed value, maximum, count and tree levels.
interface mhpq_rsp_if;
    import mhpq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] top_value;
    logic [COUNT_W-1:0]       entry_count;
    logic [LEVELS_W-1:0]      tree_levels;

    modport source (output valid, output status, output removed_value, output top_value,
                    output entry_count, output tree_levels, input ready);
    modport sink (input valid, input status, input removed_value, input top_value,
                  input entry_count, input tree_levels, output ready);
endinterface

// ===== rtl/mhpq_ctrl.sv =====
// Sequencing state machine for the heap operations.
module mhpq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  mhpq_pkg::stat_t stat,
    output mhpq_pkg::cmd_t  cmd
);
    import mhpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (stat.req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.func)
                    FUNC_INSERT:     state_next = stat.full ? S_TOP_RD : S_UP_RD;
                    FUNC_REMOVE_MAX: state_next = stat.empty ? S_TOP_RD : S_RM_LD;
                    FUNC_DELETE:     state_next = S_SCAN;
                    FUNC_SEARCH:     state_next = S_SCAN;
                    default:         state_next = S_TOP_RD;
                endcase
            end
            S_UP_RD:   state_next = stat.hole_zero ? S_TOP_RD : S_UP_CMP;
            S_UP_CMP:  state_next = stat.up_greater ? S_UP_RD : S_TOP_RD;
            S_RM_LD:   state_next = S_TAKE;
            S_SCAN:
            begin
                if (stat.scan_found)
                begin
                    state_next = (stat.func == FUNC_DELETE) ? S_TAKE : S_TOP_RD;
                end
                else if (stat.scan_miss)
                begin
                    state_next = S_TOP_RD;
                end
            end
            S_TAKE:    state_next = stat.take_fill ? S_TAKE_LD : S_TOP_RD;
            S_TAKE_LD: state_next = S_DN_RDL;
            S_DN_RDL:
            begin
                if (stat.left_exists)
                begin
                    state_next = S_DN_LATL;
                end
                else
                begin
                    state_next = stat.moved ? S_TOP_RD : S_UP_RD;
                end
            end
            S_DN_LATL: state_next = stat.right_exists ? S_DN_LATR : S_DN_DEC;
            S_DN_LATR: state_next = S_DN_DEC;
            S_DN_DEC:
            begin
                if (stat.child_big)
                begin
                    state_next = S_DN_RDL;
                end
                else
                begin
                    state_next = stat.moved ? S_TOP_RD : S_UP_RD;
                end
            end
            S_TOP_RD:  state_next = S_TOP_LD;
            S_TOP_LD:  state_next = S_FIN;
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.req_ready = 1'b0;
        cmd.op        = DP_NONE;
        unique case (state_reg)
            S_IDLE:    cmd.req_ready = 1'b1;
            S_DISPATCH:
            begin
                unique case (stat.func)
                    FUNC_INSERT:     cmd.op = stat.full ? DP_SET_FULL : DP_INS_PLACE;
                    FUNC_REMOVE_MAX: cmd.op = stat.empty ? DP_SET_EMPTY : DP_READ_ROOT;
                    FUNC_DELETE:     cmd.op = DP_NONE;
                    FUNC_SEARCH:     cmd.op = DP_NONE;
                    default:         cmd.op = DP_NONE;
                endcase
            end
            S_UP_RD:   cmd.op = stat.hole_zero ? DP_WRITE_VAL : DP_UP_READ;
            S_UP_CMP:  cmd.op = stat.up_greater ? DP_UP_MOVE : DP_WRITE_VAL;
            S_RM_LD:   cmd.op = DP_LATCH_REMOVED;
            S_SCAN:    cmd.op = DP_SCAN;
            S_TAKE:    cmd.op = DP_TAKE;
            S_TAKE_LD: cmd.op = DP_TAKE_LOAD;
            S_DN_RDL:
            begin
                if (stat.left_exists)
                begin
                    cmd.op = DP_DN_READ_L;
                end
                else
                begin
                    cmd.op = stat.moved ? DP_WRITE_VAL : DP_NONE;
                end
            end
            S_DN_LATL: cmd.op = DP_DN_LATCH_L;
            S_DN_LATR: cmd.op = DP_DN_LATCH_R;
            S_DN_DEC:
            begin
                if (stat.child_big)
                begin
                    cmd.op = DP_DN_MOVE;
                end
                else
                begin
                    cmd.op = stat.moved ? DP_WRITE_VAL : DP_NONE;
                end
            end
            S_TOP_RD:  cmd.op = DP_READ_ROOT;
            S_TOP_LD:  cmd.op = DP_TOP_LATCH;
            S_FIN:     cmd.op = stat.out_free ? DP_OUT_LOAD : DP_NONE;
            default:   cmd.op = DP_NONE;
        endcase
    end

endmodule

// ===== rtl/mhpq_datapath.sv =====
// Heap storage, working registers, scan logic and result register.
module mhpq_datapath #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mhpq_pkg::cmd_t  cmd,
    output mhpq_pkg::stat_t stat,
    mhpq_req_if.sink        req,
    mhpq_rsp_if.source      rsp
);
    import mhpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [VALUE_WIDTH-1:0] heap_mem [CAPACITY];

    logic                          mem_we;
    logic                          mem_re;
    logic [IW-1:0]                 mem_waddr;
    logic [IW-1:0]                 mem_raddr;
    logic signed [VALUE_WIDTH-1:0] mem_wdata;
    logic signed [VALUE_WIDTH-1:0] rdata_reg;

    func_t                         func_reg, func_next;
    logic signed [VALUE_WIDTH-1:0] target_reg, target_next;
    logic signed [VALUE_WIDTH-1:0] val_reg, val_next;
    logic signed [VALUE_WIDTH-1:0] child_reg, child_next;
    logic signed [VALUE_WIDTH-1:0] removed_reg, removed_next;
    logic signed [VALUE_WIDTH-1:0] top_reg, top_next;
    status_t                       status_reg, status_next;
    logic [IW-1:0]                 hole_reg, hole_next;
    logic [IW-1:0]                 pos_reg, pos_next;
    logic [IW-1:0]                 cidx_reg, cidx_next;
    logic [IW-1:0]                 pend_idx_reg, pend_idx_next;
    logic [CW-1:0]                 scan_idx_reg, scan_idx_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          cbig_reg, cbig_next;
    logic                          moved_reg, moved_next;
    logic                          pend_reg, pend_next;

    logic                          out_valid_reg, out_valid_next;
    status_t                       out_status_reg, out_status_next;
    logic signed [DATA_W-1:0]      out_removed_reg, out_removed_next;
    logic signed [DATA_W-1:0]      out_top_reg, out_top_next;
    logic [COUNT_W-1:0]            out_count_reg, out_count_next;
    logic [LEVELS_W-1:0]           out_levels_reg, out_levels_next;

    logic [IW+1:0]                 l_idx;
    logic [IW+1:0]                 r_idx;
    logic [IW+1:0]                 cnt_ext;
    logic [IW-1:0]                 parent_idx;
    logic [CW-1:0]                 cnt_dec;
    logic                          scan_match;
    logic                          scan_miss;
    logic                          req_accept;
    logic signed [VALUE_WIDTH-1:0] best_val;
    logic [LEVELS_W-1:0]           levels;

    assign l_idx      = {1'b0, hole_reg, 1'b1};
    assign r_idx      = l_idx + (IW + 2)'(1);
    assign cnt_ext    = (IW + 2)'(cnt_reg);
    assign parent_idx = (hole_reg - IW'(1)) >> 1;
    assign cnt_dec    = cnt_reg - CW'(1);
    assign scan_match = pend_reg && (rdata_reg == target_reg);
    assign scan_miss  = !scan_match && (scan_idx_reg >= cnt_reg);
    assign best_val   = cbig_reg ? child_reg : val_reg;
    assign req_accept = req.valid && req.ready;
    assign req.ready  = cmd.req_ready;

    always_comb
    begin
        levels = '0;
        for (int k = 0; k < CW; k++)
        begin
            if (cnt_reg[k])
            begin
                levels = LEVELS_W'(k + 1);
            end
        end
    end

    always_comb
    begin
        stat.req_valid    = req.valid;
        stat.func         = func_reg;
        stat.full         = (cnt_reg == CW'(CAPACITY));
        stat.empty        = (cnt_reg == '0);
        stat.hole_zero    = (hole_reg == '0);
        stat.up_greater   = (val_reg > rdata_reg);
        stat.left_exists  = (l_idx < cnt_ext);
        stat.right_exists = (r_idx < cnt_ext);
        stat.child_big    = cbig_reg;
        stat.moved        = moved_reg;
        stat.scan_found   = scan_match;
        stat.scan_miss    = scan_miss;
        stat.take_fill    = (CW'(pos_reg) < cnt_dec);
        stat.out_free     = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        func_next        = func_reg;
        target_next      = target_reg;
        val_next         = val_reg;
        child_next       = child_reg;
        removed_next     = removed_reg;
        top_next         = top_reg;
        status_next      = status_reg;
        hole_next        = hole_reg;
        pos_next         = pos_reg;
        cidx_next        = cidx_reg;
        pend_idx_next    = pend_idx_reg;
        scan_idx_next    = scan_idx_reg;
        cnt_next         = cnt_reg;
        cbig_next        = cbig_reg;
        moved_next       = moved_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_removed_next = out_removed_reg;
        out_top_next     = out_top_reg;
        out_count_next   = out_count_reg;
        out_levels_next  = out_levels_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = hole_reg;
        mem_raddr        = '0;
        mem_wdata        = val_reg;

        unique case (cmd.op)
            DP_NONE:      ;
            DP_SET_FULL:  status_next = ST_FULL;
            DP_SET_EMPTY: status_next = ST_EMPTY;
            DP_INS_PLACE:
            begin
                hole_next = cnt_reg[IW-1:0];
                cnt_next  = cnt_reg + CW'(1);
            end
            DP_UP_READ:
            begin
                mem_re    = 1'b1;
                mem_raddr = parent_idx;
            end
            DP_UP_MOVE:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
                hole_next = parent_idx;
            end
            DP_WRITE_VAL: mem_we = 1'b1;
            DP_READ_ROOT: mem_re = 1'b1;
            DP_LATCH_REMOVED:
            begin
                removed_next = rdata_reg;
                pos_next     = '0;
            end
            DP_SCAN:
            begin
                if (scan_match)
                begin
                    pos_next  = pend_idx_reg;
                    pend_next = 1'b0;
                end
                else if (scan_miss)
                begin
                    status_next = ST_NOT_FOUND;
                    pend_next   = 1'b0;
                end
                else
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = scan_idx_reg[IW-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
            end
            DP_TAKE:
            begin
                cnt_next  = cnt_dec;
                mem_re    = 1'b1;
                mem_raddr = cnt_dec[IW-1:0];
            end
            DP_TAKE_LOAD:
            begin
                val_next   = rdata_reg;
                hole_next  = pos_reg;
                moved_next = 1'b0;
            end
            DP_DN_READ_L:
            begin
                mem_re    = 1'b1;
                mem_raddr = l_idx[IW-1:0];
            end
            DP_DN_LATCH_L:
            begin
                child_next = rdata_reg;
                cidx_next  = l_idx[IW-1:0];
                cbig_next  = (rdata_reg > val_reg);
                mem_re     = 1'b1;
                mem_raddr  = r_idx[IW-1:0];
            end
            DP_DN_LATCH_R:
            begin
                if (rdata_reg > best_val)
                begin
                    child_next = rdata_reg;
                    cidx_next  = r_idx[IW-1:0];
                    cbig_next  = 1'b1;
                end
            end
            DP_DN_MOVE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = child_reg;
                hole_next  = cidx_reg;
                moved_next = 1'b1;
                cbig_next  = 1'b0;
            end
            DP_TOP_LATCH: top_next = (cnt_reg == '0) ? '0 : rdata_reg;
            DP_OUT_LOAD:
            begin
                out_valid_next   = 1'b1;
                out_status_next  = status_reg;
                out_removed_next = DATA_W'(removed_reg);
                out_top_next     = DATA_W'(top_reg);
                out_count_next   = COUNT_W'(cnt_reg);
                out_levels_next  = levels;
            end
            default: ;
        endcase

        if (req_accept)
        begin
            func_next     = func_t'(req.func);
            target_next   = VALUE_WIDTH'(req.value);
            val_next      = VALUE_WIDTH'(req.value);
            status_next   = ST_OK;
            removed_next  = '0;
            scan_idx_next = '0;
            pend_next     = 1'b0;
            moved_next    = 1'b0;
            cbig_next     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= heap_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            cbig_reg      <= 1'b0;
            moved_reg     <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            cbig_reg      <= cbig_next;
            moved_reg     <= moved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        target_reg      <= target_next;
        val_reg         <= val_next;
        child_reg       <= child_next;
        removed_reg     <= removed_next;
        top_reg         <= top_next;
        status_reg      <= status_next;
        hole_reg        <= hole_next;
        pos_reg         <= pos_next;
        cidx_reg        <= cidx_next;
        pend_idx_reg    <= pend_idx_next;
        scan_idx_reg    <= scan_idx_next;
        out_status_reg  <= out_status_next;
        out_removed_reg <= out_removed_next;
        out_top_reg     <= out_top_next;
        out_count_reg   <= out_count_next;
        out_levels_reg  <= out_levels_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.removed_value = out_removed_reg;
    assign rsp.top_value     = out_top_reg;
    assign rsp.entry_count   = out_count_reg;
    assign rsp.tree_levels   = out_levels_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + CW'(1)) ||
        (cnt_reg == $past(cnt_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("heap memory read and written in the same cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_OUT_LOAD) |-> (!out_valid_reg || rsp.ready))
        else $error("result register loaded while still holding a result");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_OUT_LOAD) |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// ===== rtl/max_heap_priority_queue_core.sv =====
// Top level of the bounded max-heap priority queue.
// The queue holds up to CAPACITY signed values in a binary heap kept in a single-port
// memory, and takes one request at a time: insert, remove maximum, delete first match,
// or search. Every request returns one result with the status, the removed maximum,
// the new maximum, the entry count and the number of tree levels. Request time is set
// by the single memory port, one access per cycle: insert takes longer the more levels
// the value climbs, remove maximum the more levels the filler value sinks, and delete
// or search first scan one entry per cycle, after which a delete restores heap order
// like a remove. With 64 entries the slowest request is a delete near the end of a
// full heap. A finished result waits in an output register while the next request
// is accepted.
module max_heap_priority_queue_core #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input logic        clk,
    input logic        rst_n,
    mhpq_req_if.sink   req,
    mhpq_rsp_if.source rsp
);
    import mhpq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mhpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    mhpq_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
